/* design/pac_pkg.sv */
// ----------------------------------------------------------------------------
// pac_pkg
// Shared types and constants of the polygon area and centroid block.
// ----------------------------------------------------------------------------
package pac_pkg;

  localparam int unsigned MUL_W  = 33;  // operand width of the shared multiplier
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned ACC_W  = 98;  // moment magnitude before clipping
  localparam int unsigned DSUM_W = 58;
  localparam int unsigned MOM_W  = 64;
  localparam int unsigned AREA_W = 56;
  localparam int unsigned DEN_W  = 60;  // three times the doubled area magnitude
  localparam int unsigned REM_W  = DEN_W + 1;
  localparam int unsigned QUO_W  = 65;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned TRI_LAST_STEP = 11;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_P1,
    OP_P2,
    OP_TRI,
    OP_DSUM,
    OP_LO,
    OP_HI,
    OP_ACC,
    OP_MOM,
    OP_FIN,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_DIVEND,
    OP_OUT
  } pac_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRI,
    ST_FIN,
    ST_DIVINIT,
    ST_DIV,
    ST_DIVEND,
    ST_OUT
  } pac_state_e;

  typedef struct packed {
    pac_op_e op;
    logic    tsel;  // 0: prior-to-vertex triangle, 1: closing triangle
    logic    axis;  // 0: x, 1: y
  } pac_cmd_t;

  typedef struct packed {
    logic zero;     // doubled area sum is zero
  } pac_stat_t;

endpackage

/* design/pac_ctrl.sv */
// ----------------------------------------------------------------------------
// pac_ctrl
// Sequencer: steps the datapath through the fan triangles, the area and the
// two centroid divisions, and owns both handshakes.
// ----------------------------------------------------------------------------
module pac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              first_vertex_i,
  input  logic              last_vertex_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pac_pkg::pac_cmd_t cmd_o,
  input  pac_pkg::pac_stat_t stat_i
);

  pac_pkg::pac_state_e state_q, state_d;
  logic [pac_pkg::STEP_W-1:0] step_q, step_d;
  logic [pac_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic tsel_q, tsel_d;
  logic axis_q, axis_d;
  logic last_q, last_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pac_pkg::ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      tsel_q      <= 1'b0;
      axis_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      tsel_q      <= tsel_d;
      axis_q      <= axis_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    tsel_d      = tsel_q;
    axis_d      = axis_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    cmd_o.op    = pac_pkg::OP_NONE;
    cmd_o.tsel  = tsel_q;
    cmd_o.axis  = axis_q;

    case (state_q)
      pac_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = pac_pkg::OP_LOAD;
          last_d   = last_vertex_i;
          step_d   = '0;
          tsel_d   = first_vertex_i;
          if (!first_vertex_i || last_vertex_i) begin
            state_d = pac_pkg::ST_TRI;
          end
        end
      end
      pac_pkg::ST_TRI: begin
        cmd_o.axis = step_q[3];
        case (step_q)
          4'd0:         cmd_o.op = pac_pkg::OP_P1;
          4'd1:         cmd_o.op = pac_pkg::OP_P2;
          4'd2:         cmd_o.op = pac_pkg::OP_TRI;
          4'd3:         cmd_o.op = pac_pkg::OP_DSUM;
          4'd4, 4'd8:   cmd_o.op = pac_pkg::OP_LO;
          4'd5, 4'd9:   cmd_o.op = pac_pkg::OP_HI;
          4'd6, 4'd10:  cmd_o.op = pac_pkg::OP_ACC;
          4'd7, 4'd11:  cmd_o.op = pac_pkg::OP_MOM;
          default:      cmd_o.op = pac_pkg::OP_NONE;
        endcase
        if (step_q == pac_pkg::STEP_W'(pac_pkg::TRI_LAST_STEP)) begin
          step_d = '0;
          if (tsel_q) begin
            state_d = pac_pkg::ST_FIN;
          end else if (last_q) begin
            tsel_d = 1'b1;
          end else begin
            state_d = pac_pkg::ST_IDLE;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      pac_pkg::ST_FIN: begin
        cmd_o.op = pac_pkg::OP_FIN;
        axis_d   = 1'b0;
        state_d  = stat_i.zero ? pac_pkg::ST_OUT : pac_pkg::ST_DIVINIT;
      end
      pac_pkg::ST_DIVINIT: begin
        cmd_o.op = pac_pkg::OP_DIVINIT;
        cnt_d    = '0;
        state_d  = pac_pkg::ST_DIV;
      end
      pac_pkg::ST_DIV: begin
        cmd_o.op = pac_pkg::OP_DIVSTEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == pac_pkg::CNT_W'(pac_pkg::DIV_STEPS - 1)) begin
          state_d = pac_pkg::ST_DIVEND;
        end
      end
      pac_pkg::ST_DIVEND: begin
        cmd_o.op = pac_pkg::OP_DIVEND;
        if (axis_q) begin
          state_d = pac_pkg::ST_OUT;
        end else begin
          axis_d  = 1'b1;
          state_d = pac_pkg::ST_DIVINIT;
        end
      end
      pac_pkg::ST_OUT: begin
        // hold the result until the output register frees up
        if (slot_free) begin
          cmd_o.op    = pac_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = pac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pac_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/pac_dp.sv */
// ----------------------------------------------------------------------------
// pac_dp
// Datapath: ring registers, one shared 33x33 multiplier, saturating
// accumulators, a radix-2 restoring divider and the output register.
// ----------------------------------------------------------------------------
module pac_dp #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pac_pkg::pac_cmd_t              cmd_i,
  output pac_pkg::pac_stat_t             stat_o,
  input  logic signed [COORD_BITS-1:0]   vertex_x_i,
  input  logic signed [COORD_BITS-1:0]   vertex_y_i,
  input  logic signed [COORD_BITS-1:0]   site_x_i,
  input  logic signed [COORD_BITS-1:0]   site_y_i,
  input  logic                           first_vertex_i,
  output logic signed [pac_pkg::AREA_W-1:0] cell_area_o,
  output logic signed [COORD_BITS-1:0]   centroid_x_o,
  output logic signed [COORD_BITS-1:0]   centroid_y_o,
  output logic                           zero_area_o,
  output logic                           saturated_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam logic [pac_pkg::PROD_W-1:0] PMAX = {{(pac_pkg::PROD_W-63){1'b0}}, {63{1'b1}}};

  // model state
  logic signed [CB-1:0] site_x_q, site_y_q, start_x_q, start_y_q;
  logic signed [CB-1:0] prior_x_q, prior_y_q, cur_x_q, cur_y_q;
  logic signed [pac_pkg::DSUM_W-1:0] dsum_q;
  logic signed [pac_pkg::MOM_W-1:0]  mom_x_q, mom_y_q;
  logic clip_q;

  // working registers
  logic [pac_pkg::PROD_W-1:0] prod_q;
  logic prod_neg_q;
  logic signed [63:0] p1_q;
  logic [62:0] tri_mag_q;
  logic tri_neg_q;
  logic [pac_pkg::ACC_W-1:0] acc_q;
  logic [pac_pkg::DEN_W-1:0] den_q;
  logic [pac_pkg::REM_W-1:0] rem_q;
  logic [pac_pkg::QUO_W-1:0] num_q;
  logic div_neg_q;
  logic signed [CB-1:0] cen_x_q, cen_y_q;
  logic signed [pac_pkg::AREA_W-1:0] area_q;
  logic zero_q, sat_q;
  logic signed [pac_pkg::AREA_W-1:0] out_area_q;
  logic signed [CB-1:0] out_x_q, out_y_q;
  logic out_zero_q, out_sat_q;

  // triangle corners
  logic signed [CB-1:0] bx, by, cx, cy;
  logic signed [CB:0] dx1, dy1, dx2, dy2;
  logic [CB:0] mdx1, mdy1, mdx2, mdy2;
  logic signed [CB+1:0] sum_c;
  logic [CB+1:0] msum;

  // multiplier
  logic [pac_pkg::MUL_W-1:0] mul_a, mul_b;
  logic mul_neg;

  // saturated product
  logic [62:0] pmag;
  logic pclip;
  logic signed [63:0] psig;

  // triangle difference
  logic signed [64:0] d65;
  logic [64:0] dmag65;
  logic signed [63:0] tri_s;

  // area sum
  logic signed [65:0] dsum_add;
  logic dsum_ovf;
  logic [pac_pkg::DSUM_W-1:0] dmag;

  // moment
  logic [62:0] mmag63;
  logic mclip;
  logic signed [63:0] msig;
  logic signed [pac_pkg::MOM_W-1:0] mom_sel;
  logic signed [pac_pkg::MOM_W:0] mom_add;
  logic mom_ovf;
  logic [pac_pkg::QUO_W-1:0] mom_mag;

  // area rounding
  logic [pac_pkg::DSUM_W:0] dinc;
  logic [pac_pkg::DSUM_W-1:0] half;

  // divider
  logic [pac_pkg::DEN_W-1:0] den3;
  logic [pac_pkg::REM_W-1:0] r2;
  logic ge;
  logic [pac_pkg::QUO_W-1:0] qlim;
  logic signed [CB-1:0] cval;
  logic cclip;

  assign bx = cmd_i.tsel ? cur_x_q : prior_x_q;
  assign by = cmd_i.tsel ? cur_y_q : prior_y_q;
  assign cx = cmd_i.tsel ? start_x_q : cur_x_q;
  assign cy = cmd_i.tsel ? start_y_q : cur_y_q;

  assign dx1  = (CB+1)'(bx) - (CB+1)'(site_x_q);
  assign dy1  = (CB+1)'(by) - (CB+1)'(site_y_q);
  assign dx2  = (CB+1)'(cx) - (CB+1)'(site_x_q);
  assign dy2  = (CB+1)'(cy) - (CB+1)'(site_y_q);
  assign mdx1 = dx1[CB] ? (CB+1)'(-dx1) : (CB+1)'(dx1);
  assign mdy1 = dy1[CB] ? (CB+1)'(-dy1) : (CB+1)'(dy1);
  assign mdx2 = dx2[CB] ? (CB+1)'(-dx2) : (CB+1)'(dx2);
  assign mdy2 = dy2[CB] ? (CB+1)'(-dy2) : (CB+1)'(dy2);

  assign sum_c = cmd_i.axis
      ? (CB+2)'(site_y_q) + (CB+2)'(by) + (CB+2)'(cy)
      : (CB+2)'(site_x_q) + (CB+2)'(bx) + (CB+2)'(cx);
  assign msum = sum_c[CB+1] ? (CB+2)'(-sum_c) : (CB+2)'(sum_c);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cmd_i.op)
      pac_pkg::OP_P1: begin
        mul_a   = pac_pkg::MUL_W'(mdx1);
        mul_b   = pac_pkg::MUL_W'(mdy2);
        mul_neg = dx1[CB] ^ dy2[CB];
      end
      pac_pkg::OP_P2: begin
        mul_a   = pac_pkg::MUL_W'(mdy1);
        mul_b   = pac_pkg::MUL_W'(mdx2);
        mul_neg = dy1[CB] ^ dx2[CB];
      end
      pac_pkg::OP_LO: begin
        mul_a   = pac_pkg::MUL_W'(tri_mag_q[31:0]);
        mul_b   = pac_pkg::MUL_W'(msum[CB:0]);
        mul_neg = tri_neg_q ^ sum_c[CB+1];
      end
      pac_pkg::OP_HI: begin
        mul_a   = pac_pkg::MUL_W'(tri_mag_q[62:32]);
        mul_b   = pac_pkg::MUL_W'(msum[CB:0]);
        mul_neg = prod_neg_q;
      end
      pac_pkg::OP_ACC: begin
        // carry the moment sign on to the update step
        mul_neg = prod_neg_q;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // clip a product magnitude to the 64-bit range
  assign pclip = prod_q > PMAX;
  assign pmag  = pclip ? {63{1'b1}} : prod_q[62:0];
  assign psig  = prod_neg_q ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});

  assign d65    = 65'(p1_q) - 65'(psig);
  assign dmag65 = d65[64] ? 65'(-d65) : 65'(d65);
  assign tri_s  = tri_neg_q ? -$signed({1'b0, tri_mag_q}) : $signed({1'b0, tri_mag_q});

  assign dsum_add = 66'(dsum_q) + 66'(tri_s);
  assign dsum_ovf = !((&dsum_add[65:pac_pkg::DSUM_W-1]) || !(|dsum_add[65:pac_pkg::DSUM_W-1]));
  assign dmag     = dsum_q[pac_pkg::DSUM_W-1] ? pac_pkg::DSUM_W'(-dsum_q)
                                              : pac_pkg::DSUM_W'(dsum_q);

  assign mclip   = acc_q > pac_pkg::ACC_W'(PMAX);
  assign mmag63  = mclip ? {63{1'b1}} : acc_q[62:0];
  assign msig    = prod_neg_q ? -$signed({1'b0, mmag63}) : $signed({1'b0, mmag63});
  assign mom_sel = cmd_i.axis ? mom_y_q : mom_x_q;
  assign mom_add = 65'(mom_sel) + 65'(msig);
  assign mom_ovf = mom_add[64] != mom_add[63];
  assign mom_mag = mom_sel[pac_pkg::MOM_W-1] ? pac_pkg::QUO_W'(-65'(mom_sel))
                                             : pac_pkg::QUO_W'(mom_sel);

  assign dinc = (pac_pkg::DSUM_W+1)'(dmag) + 1'b1;
  assign half = dinc[pac_pkg::DSUM_W:1];

  assign den3 = pac_pkg::DEN_W'(dmag) + (pac_pkg::DEN_W'(dmag) << 1);
  assign r2   = {rem_q[pac_pkg::REM_W-2:0], num_q[pac_pkg::QUO_W-1]};
  assign ge   = r2 >= pac_pkg::REM_W'(den_q);

  assign qlim = pac_pkg::QUO_W'(1) << (CB - 1);
  always_comb begin
    cclip = 1'b0;
    cval  = '0;
    if (div_neg_q) begin
      if (num_q > qlim) begin
        cclip = 1'b1;
        cval  = -$signed(CB'(qlim));
      end else begin
        cval  = -$signed(num_q[CB-1:0]);
      end
    end else begin
      if (num_q > qlim - 1'b1) begin
        cclip = 1'b1;
        cval  = $signed(CB'(qlim - 1'b1));
      end else begin
        cval  = $signed(num_q[CB-1:0]);
      end
    end
  end

  assign stat_o.zero = dsum_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_x_q  <= '0;
      site_y_q  <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
      prior_x_q <= '0;
      prior_y_q <= '0;
      dsum_q    <= '0;
      mom_x_q   <= '0;
      mom_y_q   <= '0;
      clip_q    <= 1'b0;
    end else begin
      case (cmd_i.op)
        pac_pkg::OP_LOAD: begin
          if (first_vertex_i) begin
            site_x_q  <= site_x_i;
            site_y_q  <= site_y_i;
            start_x_q <= vertex_x_i;
            start_y_q <= vertex_y_i;
            prior_x_q <= vertex_x_i;
            prior_y_q <= vertex_y_i;
            dsum_q    <= '0;
            mom_x_q   <= '0;
            mom_y_q   <= '0;
            clip_q    <= 1'b0;
          end
        end
        pac_pkg::OP_P2: begin
          if (pclip) clip_q <= 1'b1;
        end
        pac_pkg::OP_TRI: begin
          if (pclip || dmag65 > 65'(PMAX)) clip_q <= 1'b1;
        end
        pac_pkg::OP_DSUM: begin
          if (dsum_ovf) begin
            clip_q <= 1'b1;
            dsum_q <= dsum_add[65] ? {1'b1, {(pac_pkg::DSUM_W-1){1'b0}}}
                                   : {1'b0, {(pac_pkg::DSUM_W-1){1'b1}}};
          end else begin
            dsum_q <= dsum_add[pac_pkg::DSUM_W-1:0];
          end
        end
        pac_pkg::OP_MOM: begin
          if (mclip || mom_ovf) clip_q <= 1'b1;
          if (cmd_i.axis) begin
            if (mom_ovf) mom_y_q <= mom_add[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else mom_y_q <= mom_add[63:0];
            // advance the ring once the prior-to-vertex triangle is in
            if (!cmd_i.tsel) begin
              prior_x_q <= cur_x_q;
              prior_y_q <= cur_y_q;
            end
          end else begin
            if (mom_ovf) mom_x_q <= mom_add[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else mom_x_q <= mom_add[63:0];
          end
        end
        default: begin
          clip_q <= clip_q;
        end
      endcase
    end
  end

  // working and result registers, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q     <= mul_a * mul_b;
    prod_neg_q <= mul_neg;
    case (cmd_i.op)
      pac_pkg::OP_LOAD: begin
        cur_x_q <= vertex_x_i;
        cur_y_q <= vertex_y_i;
      end
      pac_pkg::OP_P2: begin
        p1_q <= psig;
      end
      pac_pkg::OP_TRI: begin
        tri_neg_q <= d65[64];
        tri_mag_q <= (dmag65 > 65'(PMAX)) ? {63{1'b1}} : dmag65[62:0];
      end
      pac_pkg::OP_HI: begin
        acc_q <= pac_pkg::ACC_W'(prod_q);
      end
      pac_pkg::OP_ACC: begin
        acc_q <= acc_q + (pac_pkg::ACC_W'(prod_q) << 32);
      end
      pac_pkg::OP_FIN: begin
        zero_q  <= dsum_q == '0;
        cen_x_q <= site_x_q;
        cen_y_q <= site_y_q;
        if (dsum_q[pac_pkg::DSUM_W-1]) begin
          if (half > (pac_pkg::DSUM_W'(1) << (pac_pkg::AREA_W - 1))) begin
            area_q <= {1'b1, {(pac_pkg::AREA_W-1){1'b0}}};
            sat_q  <= 1'b1;
          end else begin
            area_q <= -$signed(half[pac_pkg::AREA_W-1:0]);
            sat_q  <= clip_q;
          end
        end else begin
          if (half > {{(pac_pkg::DSUM_W-pac_pkg::AREA_W+1){1'b0}},
                      {(pac_pkg::AREA_W-1){1'b1}}}) begin
            area_q <= {1'b0, {(pac_pkg::AREA_W-1){1'b1}}};
            sat_q  <= 1'b1;
          end else begin
            area_q <= $signed(half[pac_pkg::AREA_W-1:0]);
            sat_q  <= clip_q;
          end
        end
      end
      pac_pkg::OP_DIVINIT: begin
        den_q     <= den3;
        rem_q     <= '0;
        num_q     <= mom_mag + pac_pkg::QUO_W'(den3 >> 1);
        div_neg_q <= mom_sel[pac_pkg::MOM_W-1] ^ dsum_q[pac_pkg::DSUM_W-1];
      end
      pac_pkg::OP_DIVSTEP: begin
        rem_q <= ge ? r2 - pac_pkg::REM_W'(den_q) : r2;
        num_q <= {num_q[pac_pkg::QUO_W-2:0], ge};
      end
      pac_pkg::OP_DIVEND: begin
        if (cmd_i.axis) cen_y_q <= cval;
        else cen_x_q <= cval;
        if (cclip) sat_q <= 1'b1;
      end
      pac_pkg::OP_OUT: begin
        out_area_q <= area_q;
        out_x_q    <= cen_x_q;
        out_y_q    <= cen_y_q;
        out_zero_q <= zero_q;
        out_sat_q  <= sat_q;
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign cell_area_o  = out_area_q;
  assign centroid_x_o = out_x_q;
  assign centroid_y_o = out_y_q;
  assign zero_area_o  = out_zero_q;
  assign saturated_o  = out_sat_q;

endmodule

/* design/polygon_area_centroid.sv */
// A vertex that is neither first nor last is accepted and then runs one fan
// triangle on the shared multiplier; a first vertex alone is only accepted.
// A last vertex runs up to two triangles, area rounding and two 65-step
// restoring divisions; the divisions are skipped when the area is zero.
// One item at a time; the result sits in an output register, so the next
// item is taken while it waits. Reset clears all sums, start, prior and site.
// ----------------------------------------------------------------------------
// polygon_area_centroid
// Signed area and area-weighted centroid of a polygon cell, built as a fan
// of triangles around the cell site.
// ----------------------------------------------------------------------------
module polygon_area_centroid #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      vertex_x_i,
  input  logic signed [COORD_BITS-1:0]      vertex_y_i,
  input  logic signed [COORD_BITS-1:0]      site_x_i,
  input  logic signed [COORD_BITS-1:0]      site_y_i,
  input  logic                              first_vertex_i,
  input  logic                              last_vertex_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pac_pkg::AREA_W-1:0] cell_area_o,
  output logic signed [COORD_BITS-1:0]      centroid_x_o,
  output logic signed [COORD_BITS-1:0]      centroid_y_o,
  output logic                              zero_area_o,
  output logic                              saturated_o
);

  pac_pkg::pac_cmd_t  cmd;
  pac_pkg::pac_stat_t stat;

  pac_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_vertex_i (first_vertex_i),
    .last_vertex_i  (last_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cmd_o          (cmd),
    .stat_i         (stat)
  );

  pac_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .site_x_i       (site_x_i),
    .site_y_i       (site_y_i),
    .first_vertex_i (first_vertex_i),
    .cell_area_o    (cell_area_o),
    .centroid_x_o   (centroid_x_o),
    .centroid_y_o   (centroid_y_o),
    .zero_area_o    (zero_area_o),
    .saturated_o    (saturated_o)
  );

endmodule

/* design/pac_chk.sv */
// ----------------------------------------------------------------------------
// pac_chk
// Port-level checks of the polygon area and centroid block.
// ----------------------------------------------------------------------------
module pac_chk #(
  parameter int unsigned COORD_BITS = 24
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              first_vertex_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [pac_pkg::AREA_W-1:0] cell_area_o,
  input logic signed [COORD_BITS-1:0]      centroid_x_o,
  input logic                              zero_area_o
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cell_area_o) && $stable(centroid_x_o))
    else $error("stalled result beat changed");

  // rounding keeps any nonzero doubled area nonzero
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (zero_area_o == (cell_area_o == '0)))
    else $error("zero_area flag disagrees with area");

  // a non-first vertex adds a triangle and keeps the input busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !first_vertex_i |=> in_stall_o)
    else $error("input taken while a triangle is in progress");

endmodule

bind polygon_area_centroid pac_chk #(
  .COORD_BITS (COORD_BITS)
) u_pac_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .first_vertex_i (first_vertex_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .cell_area_o    (cell_area_o),
  .centroid_x_o   (centroid_x_o),
  .zero_area_o    (zero_area_o)
);
